### rtl/dehs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Drive-enable handshake package
// Shared word types, mode encodings, operation codes and register map.
// ----------------------------------------------------------------------------
package dehs_pkg;

    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Operation codes of an input word
    localparam logic [1:0] OP_FEEDBACK  = 2'd0;
    localparam logic [1:0] OP_CTRL_SENT = 2'd1;
    localparam logic [1:0] OP_STAT_SENT = 2'd2;
    localparam logic [1:0] OP_USER_REQ  = 2'd3;

    // Mode codes as seen on the result word
    localparam logic [1:0] MODE_DISABLED  = 2'd0;
    localparam logic [1:0] MODE_REQUESTED = 2'd1;
    localparam logic [1:0] MODE_SENT      = 2'd2;
    localparam logic [1:0] MODE_ENABLED   = 2'd3;

    // Register indexes
    localparam logic REG_DEBOUNCE = 1'b0;

    typedef enum logic [3:0] {
        ST_DISABLED  = 4'b0001,
        ST_REQUESTED = 4'b0010,
        ST_SENT      = 4'b0100,
        ST_ENABLED   = 4'b1000
    } t_mode_state;

    typedef struct packed {
        logic [1:0] operation;
        logic       flag;
    } t_in_word;

    typedef struct packed {
        logic [1:0] mode;
        logic       is_enabled;
    } t_out_word;

    // Handshake context carried from event to event
    typedef struct packed {
        t_mode_state        state;
        logic               control_seen;
        logic               status_cmd_seen;
        logic [COUNT_W-1:0] disabled_count;
    } t_ctx;

    localparam t_ctx CTX_CLEAR = '{
        state:           ST_DISABLED,
        control_seen:    1'b0,
        status_cmd_seen: 1'b0,
        disabled_count:  '0
    };

    function automatic logic [1:0] mode_code(input t_mode_state st);
        logic [1:0] code;
        case (st)
            ST_DISABLED:  code = MODE_DISABLED;
            ST_REQUESTED: code = MODE_REQUESTED;
            ST_SENT:      code = MODE_SENT;
            ST_ENABLED:   code = MODE_ENABLED;
            default:      code = MODE_DISABLED;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

### rtl/dehs_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Drive-enable handshake configuration registers
// APB-style register file holding the disabled-feedback debounce threshold.
// ----------------------------------------------------------------------------
module dehs_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dehs_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [dehs_pkg::PDATA_W-1:0]  pwdata,
    output logic      [dehs_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    output logic      [dehs_pkg::COUNT_W-1:0]  o_threshold
);
    import dehs_pkg::*;

    logic               reg_index;
    logic               wr_en;
    logic [COUNT_W-1:0] r_threshold;

    // Decode word address
    assign reg_index = paddr[PADDR_W-1];
    assign wr_en     = psel && penable && pwrite && (reg_index == REG_DEBOUNCE);
    assign pready    = 1'b1;

    // Hold threshold, update on access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (wr_en) begin
            r_threshold <= pwdata[COUNT_W-1:0];
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        if (reg_index == REG_DEBOUNCE) begin
            prdata = {{(PDATA_W-COUNT_W){1'b0}}, r_threshold};
        end
    end

    assign o_threshold = r_threshold;

endmodule
`default_nettype wire

### rtl/dehs_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Drive-enable handshake step logic
// Next context and result word for one event, from the current context.
// ----------------------------------------------------------------------------
module dehs_step (
    input  wire dehs_pkg::t_in_word            i_word,
    input  wire dehs_pkg::t_ctx                i_ctx,
    input  wire logic [dehs_pkg::COUNT_W-1:0]  i_threshold,
    output dehs_pkg::t_ctx                     o_ctx,
    output dehs_pkg::t_out_word                o_word
);
    import dehs_pkg::*;

    logic               both_seen;
    logic [COUNT_W-1:0] count_inc;
    t_ctx               nxt;

    assign both_seen = (i_ctx.state == ST_REQUESTED) && i_ctx.control_seen
                       && i_ctx.status_cmd_seen;

    // Saturate the disabled-feedback count
    assign count_inc = (i_ctx.disabled_count == COUNT_MAX) ? i_ctx.disabled_count
                       : i_ctx.disabled_count + COUNT_W'(1);

    // Advance the handshake
    always_comb begin
        nxt = i_ctx;
        case (i_word.operation)
            OP_FEEDBACK: begin
                if (i_word.flag) begin
                    if (i_ctx.state == ST_SENT) begin
                        nxt.state          = ST_ENABLED;
                        nxt.disabled_count = '0;
                    end
                end else if (i_ctx.state == ST_SENT) begin
                    if (count_inc > i_threshold) begin
                        nxt = CTX_CLEAR;
                    end else begin
                        nxt.disabled_count = count_inc;
                    end
                end else if (i_ctx.state == ST_ENABLED) begin
                    nxt = CTX_CLEAR;
                end
            end
            OP_CTRL_SENT: begin
                if (both_seen) begin
                    nxt.state = ST_SENT;
                end else if (i_ctx.state == ST_REQUESTED) begin
                    nxt.control_seen = 1'b1;
                end
            end
            OP_STAT_SENT: begin
                if (both_seen) begin
                    nxt.state = ST_SENT;
                end else if (i_ctx.state == ST_REQUESTED) begin
                    nxt.status_cmd_seen = 1'b1;
                end
            end
            OP_USER_REQ: begin
                if (i_word.flag) begin
                    if (i_ctx.state == ST_DISABLED) begin
                        nxt.state = ST_REQUESTED;
                    end
                end else begin
                    nxt = CTX_CLEAR;
                end
            end
            default: begin
                nxt = i_ctx;
            end
        endcase
    end

    assign o_ctx             = nxt;
    assign o_word.mode       = mode_code(nxt.state);
    assign o_word.is_enabled = (nxt.state == ST_ENABLED) || (nxt.state == ST_SENT)
                               || ((nxt.state == ST_REQUESTED) && nxt.control_seen
                                   && nxt.status_cmd_seen);

endmodule
`default_nettype wire

### rtl/drive_enable_handshake_fsm_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Drive-enable handshake tracker
// Follows a drive-by-wire enable handshake; one result word per event word.
//
//   channel   | direction | handshake          | word
//   ----------+-----------+--------------------+---------------------------
//   event in  | in        | i_valid / o_ready  | i_data (operation, flag)
//   result    | out       | o_valid / i_ready  | o_data (mode, is_enabled)
//   config    | in        | APB psel/penable   | pwdata, debounce threshold
//
// One event word per cycle while results are taken; an accepted word passes
// an input register, then the step logic into the result register.
// Synchronous active-low reset clears the context, threshold and valid flags.
// A stalled result holds the result register; the input register takes one
// more word while it is empty, then o_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module drive_enable_handshake_fsm_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire dehs_pkg::t_in_word            i_data,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output dehs_pkg::t_out_word                o_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dehs_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [dehs_pkg::PDATA_W-1:0]  pwdata,
    output logic      [dehs_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);
    import dehs_pkg::*;

    logic               r_in_valid;
    t_in_word           r_in_word;
    logic               r_out_valid;
    t_out_word          r_out_word;
    t_ctx               r_ctx;
    t_ctx               n_ctx;
    t_out_word          n_out_word;
    logic [COUNT_W-1:0] threshold;
    logic               advance;
    logic               fire;

    dehs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_threshold (threshold)
    );

    dehs_step u_step (
        .i_word      (r_in_word),
        .i_ctx       (r_ctx),
        .i_threshold (threshold),
        .o_ctx       (n_ctx),
        .o_word      (n_out_word)
    );

    // Pipeline flow control
    assign advance = !r_out_valid || i_ready;
    assign fire    = r_in_valid && advance;
    assign o_ready = !r_in_valid || advance;

    // Capture event word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_word <= i_data;
        end
    end

    // Advance context on each processed event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx <= CTX_CLEAR;
        end else if (fire) begin
            r_ctx <= n_ctx;
        end
    end

    // Hold result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_word;

`ifndef ASSERT_OFF
    a_enabled_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.mode == MODE_ENABLED || o_data.mode == MODE_SENT)
        |-> o_data.is_enabled)
        else $error("result in sent or enabled mode without enabled flag");

    a_count_only_sent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctx.state != ST_SENT |-> r_ctx.disabled_count == '0)
        else $error("disabled count nonzero outside enable sent");

    a_seen_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctx.state == ST_DISABLED |-> !r_ctx.control_seen && !r_ctx.status_cmd_seen)
        else $error("command seen bits set while disabled");

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_in_valid && r_out_valid)
        else $error("input stalled with an empty stage");
`endif

endmodule
`default_nettype wire

### sim/drive_enable_handshake_fsm_core_tb.sv
// ----------------------------------------------------------------------------
// Drive-enable handshake tracker testbench
// Feeds event words through the valid/ready input channel and checks every
// result word against a cycle-free model of the enable handshake. The run
// goes through several debounce thresholds, from 0 to the maximum. One phase
// holds the tracker in enable sent under the largest threshold with a long
// run of disabled feedback. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module drive_enable_handshake_fsm_core_tb;
    import dehs_pkg::*;

    // Register addresses on the configuration port
    localparam logic [PADDR_W-1:0] ADDR_DEBOUNCE = PADDR_W'(REG_DEBOUNCE) << 2;
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = ADDR_DEBOUNCE + PADDR_W'(4);
    localparam int                 RANDOM_WORDS  = 140;
    localparam int                 HOLD_WORDS    = 160;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    t_in_word           i_data  = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    t_out_word          o_data;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Model of the handshake context and the threshold register
    logic [1:0]         hs_mode;
    logic               ctrl_cmd_seen;
    logic               stat_cmd_seen;
    logic [COUNT_W-1:0] off_count;
    logic [COUNT_W-1:0] debounce_lim;

    t_in_word  event_q[$];
    t_out_word result_q[$];
    t_out_word want;
    int        words_queued = 0;
    int        results_seen = 0;
    int        errors       = 0;
    int        send_wait    = 0;
    int        recv_wait    = 0;
    bit        quiet        = 1'b0;

    drive_enable_handshake_fsm_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void clear_handshake();
        hs_mode       = MODE_DISABLED;
        ctrl_cmd_seen = 1'b0;
        stat_cmd_seen = 1'b0;
        off_count     = '0;
    endfunction

    function automatic logic both_cmds_pending();
        return hs_mode == MODE_REQUESTED && ctrl_cmd_seen && stat_cmd_seen;
    endfunction

    // Advance the handshake by one event word and form its result word
    function automatic t_out_word advance_handshake(input t_in_word w);
        t_out_word r;
        case (w.operation)
            OP_FEEDBACK: begin
                if (w.flag) begin
                    if (hs_mode == MODE_SENT) begin
                        hs_mode   = MODE_ENABLED;
                        off_count = '0;
                    end
                end else if (hs_mode == MODE_SENT) begin
                    if (off_count != COUNT_MAX) off_count = off_count + 1'b1;
                    if (off_count > debounce_lim) clear_handshake();
                end else if (hs_mode == MODE_ENABLED) begin
                    clear_handshake();
                end
            end
            OP_CTRL_SENT: begin
                if (both_cmds_pending()) hs_mode = MODE_SENT;
                if (hs_mode == MODE_REQUESTED) ctrl_cmd_seen = 1'b1;
            end
            OP_STAT_SENT: begin
                if (both_cmds_pending()) hs_mode = MODE_SENT;
                if (hs_mode == MODE_REQUESTED) stat_cmd_seen = 1'b1;
            end
            default: begin
                if (!w.flag) begin
                    clear_handshake();
                end else if (hs_mode == MODE_DISABLED) begin
                    hs_mode = MODE_REQUESTED;
                end
            end
        endcase
        r.mode       = hs_mode;
        r.is_enabled = hs_mode == MODE_ENABLED || hs_mode == MODE_SENT || both_cmds_pending();
        return r;
    endfunction

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 12);
    endfunction

    // Drive event words from the pending queue; predict on every acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) result_q.push_back(advance_handshake(i_data));
            if (!i_valid || o_ready) begin
                if (send_wait > 0) begin
                    send_wait = send_wait - 1;
                    i_valid <= 1'b0;
                end else if (event_q.size() > 0) begin
                    i_data  <= event_q.pop_front();
                    i_valid <= 1'b1;
                    send_wait = draw_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Take result words, stall at random and compare with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                results_seen = results_seen + 1;
                if (result_q.size() == 0) begin
                    $error("unexpected result word: mode %0d is_enabled %0d",
                           o_data.mode, o_data.is_enabled);
                    errors = errors + 1;
                end else begin
                    want = result_q.pop_front();
                    if (o_data.mode !== want.mode) begin
                        $error("mode: expected %0d, got %0d", want.mode, o_data.mode);
                        errors = errors + 1;
                    end
                    if (o_data.is_enabled !== want.is_enabled) begin
                        $error("is_enabled: expected %0d, got %0d",
                               want.is_enabled, o_data.is_enabled);
                        errors = errors + 1;
                    end
                end
                recv_wait = draw_gap();
            end
            if (recv_wait > 0) begin
                recv_wait = recv_wait - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic push_word(input logic [1:0] op, input logic fl);
        t_in_word w;
        w.operation = op;
        w.flag      = fl;
        event_q.push_back(w);
        words_queued = words_queued + 1;
    endtask

    // Hold until every queued word has produced its result, then let the pipe settle
    task automatic wait_idle();
        while (results_seen != words_queued) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write a register over the configuration port; read the debounce register back
    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == ADDR_DEBOUNCE) debounce_lim = data[COUNT_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_DEBOUNCE) begin
            @(posedge i_clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            if (prdata[COUNT_W-1:0] !== debounce_lim) begin
                $error("debounce_threshold: expected %0d, got %0d",
                       debounce_lim, prdata[COUNT_W-1:0]);
                errors = errors + 1;
            end
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    // One handshake attempt (enable request, commands, feedback, maybe a disable) or noise
    task automatic add_attempt();
        int  n;
        bit  ctrl_first;
        if ($urandom_range(0, 7) == 0) begin
            // noise: any event in any order
            n = $urandom_range(1, 4);
            repeat (n) push_word(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            return;
        end
        push_word(OP_USER_REQ, 1'b1);
        if ($urandom_range(0, 9) == 0) push_word(OP_FEEDBACK, 1'($urandom_range(0, 1)));
        ctrl_first = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 7) == 0) begin
            // broken: only one command kind, never reaches enable sent
            repeat ($urandom_range(1, 3))
                push_word(ctrl_first ? OP_CTRL_SENT : OP_STAT_SENT, 1'($urandom_range(0, 1)));
        end else begin
            push_word(ctrl_first ? OP_CTRL_SENT : OP_STAT_SENT, 1'($urandom_range(0, 1)));
            push_word(ctrl_first ? OP_STAT_SENT : OP_CTRL_SENT, 1'($urandom_range(0, 1)));
            n = $urandom_range(1, 3);
            repeat (n) push_word(2'($urandom_range(1, 2)), 1'($urandom_range(0, 1)));
        end
        // disabled feedback burst against the debounce threshold
        n = $urandom_range(0, 8);
        repeat (n) push_word(OP_FEEDBACK, 1'($urandom_range(0, 4) == 0));
        if ($urandom_range(0, 1) == 0) push_word(OP_FEEDBACK, 1'b1);
        n = $urandom_range(0, 4);
        repeat (n) push_word(OP_FEEDBACK, 1'($urandom_range(0, 5) != 0));
        if ($urandom_range(0, 2) == 0) push_word(OP_USER_REQ, 1'b0);
    endtask

    task automatic run_phase(input logic [COUNT_W-1:0] lim, input bit still);
        int first;
        wait_idle();
        write_reg(ADDR_DEBOUNCE, PDATA_W'(lim));
        quiet = still;
        first = words_queued;
        while (words_queued - first < RANDOM_WORDS) add_attempt();
    endtask

    initial begin
        debounce_lim = '0;
        clear_handshake();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unmapped register: write must leave the threshold alone
        write_reg(ADDR_UNMAPPED, PDATA_W'($urandom));
        write_reg(ADDR_DEBOUNCE, PDATA_W'(1));

        // directed walk that visits every mode and drives each event kind
        push_word(OP_FEEDBACK, 1'b1);
        push_word(OP_FEEDBACK, 1'b0);
        push_word(OP_CTRL_SENT, 1'b0);
        push_word(OP_STAT_SENT, 1'b1);
        push_word(OP_USER_REQ, 1'b0);
        push_word(OP_USER_REQ, 1'b1);
        push_word(OP_USER_REQ, 1'b1);
        push_word(OP_CTRL_SENT, 1'b1);
        push_word(OP_CTRL_SENT, 1'b0);
        push_word(OP_STAT_SENT, 1'b0);
        push_word(OP_STAT_SENT, 1'b1);
        push_word(OP_USER_REQ, 1'b1);
        push_word(OP_FEEDBACK, 1'b0);
        push_word(OP_FEEDBACK, 1'b0);
        push_word(OP_USER_REQ, 1'b1);
        push_word(OP_STAT_SENT, 1'b0);
        push_word(OP_CTRL_SENT, 1'b1);
        push_word(OP_CTRL_SENT, 1'b0);
        push_word(OP_FEEDBACK, 1'b1);
        push_word(OP_CTRL_SENT, 1'b0);
        push_word(OP_FEEDBACK, 1'b1);
        push_word(OP_FEEDBACK, 1'b0);
        push_word(OP_USER_REQ, 1'b1);
        push_word(OP_USER_REQ, 1'b0);

        run_phase(COUNT_W'(0), 1'b1);
        run_phase(COUNT_W'(2), 1'b0);

        // hold enable sent under the largest threshold: disabled feedback never drops
        wait_idle();
        write_reg(ADDR_DEBOUNCE, PDATA_W'(COUNT_MAX));
        quiet = 1'b1;
        push_word(OP_USER_REQ, 1'b0);
        push_word(OP_USER_REQ, 1'b1);
        push_word(OP_CTRL_SENT, 1'b0);
        push_word(OP_STAT_SENT, 1'b0);
        push_word(OP_CTRL_SENT, 1'b0);
        repeat (HOLD_WORDS) push_word(OP_FEEDBACK, 1'b0);

        // lower threshold under a large count: the next disabled feedback drops
        wait_idle();
        write_reg(ADDR_DEBOUNCE, PDATA_W'(3));
        quiet = 1'b0;
        push_word(OP_FEEDBACK, 1'b0);
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (words_queued >= 0) add_attempt();
            if (event_q.size() >= RANDOM_WORDS) break;
        end

        run_phase(COUNT_W'($urandom_range(4, 10)), 1'b0);
        run_phase(COUNT_W'($urandom_range(0, int'(COUNT_MAX))), 1'b1);
        run_phase(COUNT_W'(1), 1'b0);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (result_q.size() != 0) begin
            $error("%0d predicted result words never arrived", result_q.size());
            errors = errors + 1;
        end
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
